// ===== hw/rtl/dtt_pkg.sv =====
// Shared types, widths and codes for the dirty tile tracker.
package dtt_pkg;

  localparam int CANVAS_W   = 13;
  localparam int TILE_IDX_W = 6;
  localparam int PIX_W      = 12;
  localparam int RECT_W     = 7;
  localparam int FUNC_W     = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FUNC_W-1:0] FUNC_RENDER    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MAIN_SCAN = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_NAV_SCAN  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MARK_ALL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RESTART   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TILE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Geometry of one tile along one axis.
  typedef struct packed {
    logic              present;
    logic [RECT_W-1:0] rect;
    logic [PIX_W-1:0]  pix;
  } geo_t;

endpackage

// ===== hw/rtl/dtt_row_mem.sv =====
// Bitmap row memory with per-row valid bits; an unwritten row reads as all ones.
module dtt_row_mem #(
  parameter int ROWS  = 64,
  parameter int WIDTH = 64,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr_all,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [ROWS];
  logic [ROWS-1:0]  vld_r;
  logic [WIDTH-1:0] q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (clr_all) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '1;

endmodule

// ===== hw/rtl/dtt_geom.sv =====
// Tile geometry along one axis: presence, rectangle size and pixel origin.
module dtt_geom #(
  parameter int TILE_SIZE = 64,
  parameter int MAX_TILES = 64,
  localparam int PROD_W   = $clog2((1 << dtt_pkg::TILE_IDX_W) * TILE_SIZE + 1),
  localparam int GEO_W    = (PROD_W > dtt_pkg::CANVAS_W) ? PROD_W : dtt_pkg::CANVAS_W
) (
  input  logic [dtt_pkg::CANVAS_W-1:0]   size,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] idx,
  output dtt_pkg::geo_t                  geo,
  output logic [GEO_W-1:0]               sat_size
);
  import dtt_pkg::*;

  localparam logic [GEO_W-1:0] LIMIT = GEO_W'(MAX_TILES * TILE_SIZE);
  localparam logic [GEO_W-1:0] TS    = GEO_W'(TILE_SIZE);

  logic [GEO_W-1:0] size_ext;
  logic [GEO_W-1:0] start;
  logic [GEO_W-1:0] remain;
  logic [GEO_W-1:0] rect_full;

  assign size_ext  = GEO_W'(size);
  assign sat_size  = (size_ext > LIMIT) ? LIMIT : size_ext;
  assign start     = GEO_W'(GEO_W'(idx) * TS);
  assign remain    = sat_size - start;
  assign rect_full = (remain < TS) ? remain : TS;

  always_comb begin
    geo.present = start < sat_size;
    geo.rect    = geo.present ? RECT_W'(rect_full) : '0;
    geo.pix     = PIX_W'(start);
  end

endmodule

// ===== hw/rtl/dtt_ctrl.sv =====
// Sequencer: row read-modify-write for render marks, column walk for scans.
module dtt_ctrl #(
  parameter int TILE_SIZE        = 64,
  parameter int MAX_TILES_ACROSS = 64,
  parameter int MAX_TILES_DOWN   = 64,
  localparam int ROW_AW = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1,
  localparam int COL_AW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1,
  localparam int PROD_W = $clog2((1 << dtt_pkg::TILE_IDX_W) * TILE_SIZE + 1),
  localparam int GEO_W  = (PROD_W > dtt_pkg::CANVAS_W) ? PROD_W : dtt_pkg::CANVAS_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dtt_pkg::FUNC_W-1:0]     in_func,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] in_tile_x,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] in_tile_y,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] in_x_last,
  input  logic                           in_all_tiles,
  input  logic                           in_end_of_pass,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dtt_pkg::KIND_W-1:0]     out_kind,
  output logic [dtt_pkg::TILE_IDX_W-1:0] out_tile_x,
  output logic [dtt_pkg::TILE_IDX_W-1:0] out_tile_y,
  output logic [dtt_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [dtt_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [dtt_pkg::RECT_W-1:0]     out_rect_width,
  output logic [dtt_pkg::RECT_W-1:0]     out_rect_height,
  output logic                           out_dirty_check,
  output logic                           out_navigator_check,
  output logic                           out_last,
  output logic [dtt_pkg::TILE_IDX_W-1:0] gx_idx,
  output logic [dtt_pkg::TILE_IDX_W-1:0] gy_idx,
  input  dtt_pkg::geo_t                  gx,
  input  dtt_pkg::geo_t                  gy,
  input  logic [GEO_W-1:0]               x_limit,
  output logic                           rd_en,
  output logic [ROW_AW-1:0]              rd_addr,
  input  logic [MAX_TILES_ACROSS-1:0]    main_rd,
  input  logic [MAX_TILES_ACROSS-1:0]    nav_rd,
  output logic [ROW_AW-1:0]              wr_addr,
  output logic                           main_wr_en,
  output logic [MAX_TILES_ACROSS-1:0]    main_wr_data,
  output logic                           nav_wr_en,
  output logic [MAX_TILES_ACROSS-1:0]    nav_wr_data,
  output logic                           main_clr,
  output logic                           nav_clr
);
  import dtt_pkg::*;

  state_t state_r, state_nxt;

  logic [FUNC_W-1:0]     func_r;
  logic [TILE_IDX_W-1:0] tx_r, ty_r, xl_r, col_r, col_nxt;
  logic                  all_r, eop_r;
  logic [MAX_TILES_ACROSS-1:0] row_r, row_nxt, pend_r, pend_nxt;
  logic                  main_pend_r, main_pend_nxt, nav_pend_r, nav_pend_nxt;

  logic                  out_valid_r;
  logic [KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic [TILE_IDX_W-1:0] out_tx_r, out_tx_nxt, out_ty_r, out_ty_nxt;
  logic [PIX_W-1:0]      out_px_r, out_px_nxt, out_py_r, out_py_nxt;
  logic [RECT_W-1:0]     out_w_r, out_w_nxt, out_h_r, out_h_nxt;
  logic                  out_dc_r, out_dc_nxt, out_nc_r, out_nc_nxt, out_last_r, out_last_nxt;
  logic                  emit;

  logic                  accept, slot_free, is_render, is_nav;
  logic [MAX_TILES_ACROSS-1:0] exec_row, span, init_pend, rest, col_onehot, tx_onehot;
  logic                  cur_hit, rest_any, render_hit, main_bit, nav_bit, dc, nc;

  assign in_ready  = state_r == ST_IDLE;
  assign gx_idx    = (state_r == ST_SCAN) ? col_r : tx_r;
  assign gy_idx    = ty_r;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign is_render = func_r == FUNC_RENDER;
  assign is_nav    = func_r == FUNC_NAV_SCAN;
  assign exec_row  = is_nav ? nav_rd : main_rd;

  // Columns of the clamped span, then the ones this scan will report.
  always_comb begin
    for (int c = 0; c < MAX_TILES_ACROSS; c++) begin
      span[c] = (TILE_IDX_W'(c) >= tx_r) && (TILE_IDX_W'(c) <= xl_r) &&
                (GEO_W'(c * TILE_SIZE) < x_limit);
      rest[c] = pend_r[c] && (TILE_IDX_W'(c) > col_r);
      col_onehot[c] = COL_AW'(c) == COL_AW'(col_r);
      tx_onehot[c]  = COL_AW'(c) == COL_AW'(tx_r);
    end
  end

  assign init_pend  = gy.present ? (span & (exec_row | {MAX_TILES_ACROSS{is_nav & all_r}}))
                                 : '0;
  assign cur_hit    = pend_r[COL_AW'(col_r)];
  assign rest_any   = |rest;
  assign render_hit = gx.present && gy.present;
  assign main_bit   = main_rd[COL_AW'(tx_r)];
  assign nav_bit    = nav_rd[COL_AW'(tx_r)];
  assign dc         = render_hit && !main_bit && !main_pend_r;
  assign nc         = render_hit && !nav_bit && !nav_pend_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_RENDER || in_func == FUNC_MAIN_SCAN ||
                       in_func == FUNC_NAV_SCAN)) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_render || init_pend == '0) begin
          if (slot_free) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cur_hit && slot_free && !rest_any) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    rd_en         = accept;
    rd_addr       = ROW_AW'(in_tile_y);
    wr_addr       = ROW_AW'(ty_r);
    main_wr_en    = 1'b0;
    nav_wr_en     = 1'b0;
    main_wr_data  = main_rd | tx_onehot;
    nav_wr_data   = nav_rd | tx_onehot;
    main_clr      = 1'b0;
    nav_clr       = 1'b0;
    main_pend_nxt = main_pend_r;
    nav_pend_nxt  = nav_pend_r;
    row_nxt       = row_r;
    pend_nxt      = pend_r;
    col_nxt       = col_r;
    emit          = 1'b0;
    out_kind_nxt  = KIND_ACK;
    out_tx_nxt    = '0;
    out_ty_nxt    = '0;
    out_px_nxt    = '0;
    out_py_nxt    = '0;
    out_w_nxt     = '0;
    out_h_nxt     = '0;
    out_dc_nxt    = 1'b0;
    out_nc_nxt    = 1'b0;
    out_last_nxt  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_func == FUNC_MARK_ALL) begin
          main_clr = 1'b1;
        end
        if (accept && in_func == FUNC_RESTART) begin
          main_clr      = 1'b1;
          nav_clr       = 1'b1;
          main_pend_nxt = 1'b1;
          nav_pend_nxt  = 1'b1;
        end
      end
      ST_EXEC: begin
        row_nxt  = exec_row;
        pend_nxt = init_pend;
        col_nxt  = tx_r;
        if (is_render) begin
          if (slot_free) begin
            emit       = 1'b1;
            out_tx_nxt = tx_r;
            out_ty_nxt = ty_r;
            out_px_nxt = gx.pix;
            out_py_nxt = gy.pix;
            out_w_nxt  = render_hit ? gx.rect : '0;
            out_h_nxt  = render_hit ? gy.rect : '0;
            out_dc_nxt = dc;
            out_nc_nxt = nc;
            main_wr_en = render_hit;
            nav_wr_en  = render_hit;
            if (dc) begin
              main_pend_nxt = 1'b1;
            end
            if (nc) begin
              nav_pend_nxt = 1'b1;
            end
          end
        end else if (init_pend == '0 && slot_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_EMPTY;
          if (eop_r && is_nav) begin
            nav_pend_nxt = 1'b0;
          end else if (eop_r) begin
            main_pend_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        main_wr_data = row_r & ~col_onehot;
        nav_wr_data  = row_r & ~col_onehot;
        if (!cur_hit) begin
          col_nxt = col_r + 1'b1;
        end else if (slot_free) begin
          emit         = 1'b1;
          out_kind_nxt = KIND_TILE;
          out_tx_nxt   = col_r;
          out_ty_nxt   = ty_r;
          out_px_nxt   = gx.pix;
          out_py_nxt   = gy.pix;
          out_w_nxt    = gx.rect;
          out_h_nxt    = gy.rect;
          out_last_nxt = !rest_any;
          row_nxt      = row_r & ~col_onehot;
          pend_nxt     = pend_r & ~col_onehot;
          col_nxt      = col_r + 1'b1;
          // Last tile of the span: write the cleared row back.
          if (!rest_any) begin
            main_wr_en = !is_nav;
            nav_wr_en  = is_nav;
            if (eop_r && is_nav) begin
              nav_pend_nxt = 1'b0;
            end else if (eop_r) begin
              main_pend_nxt = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      main_pend_r <= 1'b1;
      nav_pend_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      main_pend_r <= main_pend_nxt;
      nav_pend_r  <= nav_pend_nxt;
      out_valid_r <= emit || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      tx_r   <= in_tile_x;
      ty_r   <= in_tile_y;
      xl_r   <= in_x_last;
      all_r  <= in_all_tiles;
      eop_r  <= in_end_of_pass;
    end
    row_r  <= row_nxt;
    pend_r <= pend_nxt;
    col_r  <= col_nxt;
    if (emit) begin
      out_kind_r <= out_kind_nxt;
      out_tx_r   <= out_tx_nxt;
      out_ty_r   <= out_ty_nxt;
      out_px_r   <= out_px_nxt;
      out_py_r   <= out_py_nxt;
      out_w_r    <= out_w_nxt;
      out_h_r    <= out_h_nxt;
      out_dc_r   <= out_dc_nxt;
      out_nc_r   <= out_nc_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_tile_x          = out_tx_r;
  assign out_tile_y          = out_ty_r;
  assign out_pixel_x         = out_px_r;
  assign out_pixel_y         = out_py_r;
  assign out_rect_width      = out_w_r;
  assign out_rect_height     = out_h_r;
  assign out_dirty_check     = out_dc_r;
  assign out_navigator_check = out_nc_r;
  assign out_last            = out_last_r;

endmodule

// ===== hw/rtl/dirty_tile_tracker_core.sv =====
// Top level of the dirty tile tracker: configuration registers, bitmaps, geometry, sequencer.
// Tracks main-view and navigator dirty bitmaps over a tiled canvas, one memory row per
// tile row. A render mark reads the row, then modifies it and writes it back with the
// acknowledge. A row scan reads the row, then walks the row register one column at a time
// from tile_x up to the last tile it reports; an empty scan gives one empty result after
// the row read. Mark-all and restart finish on acceptance and need no clearing pass: per-row
// valid bits make an unwritten or cleared row read as all dirty. An output register holds
// a result, so the next item is taken while it waits. Configuration writes are always ready.
module dirty_tile_tracker_core #(
  parameter int TILE_SIZE        = 64,
  parameter int MAX_TILES_ACROSS = 64,
  parameter int MAX_TILES_DOWN   = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtt_pkg::CANVAS_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dtt_pkg::FUNC_W-1:0]     in_func,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] in_tile_x,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] in_tile_y,
  input  logic [dtt_pkg::TILE_IDX_W-1:0] in_x_last,
  input  logic                           in_all_tiles,
  input  logic                           in_end_of_pass,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dtt_pkg::KIND_W-1:0]     out_kind,
  output logic [dtt_pkg::TILE_IDX_W-1:0] out_tile_x,
  output logic [dtt_pkg::TILE_IDX_W-1:0] out_tile_y,
  output logic [dtt_pkg::PIX_W-1:0]      out_pixel_x,
  output logic [dtt_pkg::PIX_W-1:0]      out_pixel_y,
  output logic [dtt_pkg::RECT_W-1:0]     out_rect_width,
  output logic [dtt_pkg::RECT_W-1:0]     out_rect_height,
  output logic                           out_dirty_check,
  output logic                           out_navigator_check,
  output logic                           out_last
);
  import dtt_pkg::*;

  localparam int ROW_AW = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
  localparam int PROD_W = $clog2((1 << TILE_IDX_W) * TILE_SIZE + 1);
  localparam int GEO_W  = (PROD_W > CANVAS_W) ? PROD_W : CANVAS_W;

  logic [CANVAS_W-1:0] width_r, height_r;

  logic [TILE_IDX_W-1:0]       gx_idx, gy_idx;
  geo_t                        gx, gy;
  logic [GEO_W-1:0]            x_limit, y_limit;
  logic                        rd_en, main_wr_en, nav_wr_en, main_clr, nav_clr;
  logic [ROW_AW-1:0]           rd_addr, wr_addr;
  logic [MAX_TILES_ACROSS-1:0] main_rd, nav_rd, main_wr_data, nav_wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dtt_geom #(
    .TILE_SIZE (TILE_SIZE),
    .MAX_TILES (MAX_TILES_ACROSS)
  ) u_geom_x (
    .size     (width_r),
    .idx      (gx_idx),
    .geo      (gx),
    .sat_size (x_limit)
  );

  // Row extent only matters through the presence and height of the tile.
  dtt_geom #(
    .TILE_SIZE (TILE_SIZE),
    .MAX_TILES (MAX_TILES_DOWN)
  ) u_geom_y (
    .size     (height_r),
    .idx      (gy_idx),
    .geo      (gy),
    .sat_size (y_limit)
  );

  dtt_row_mem #(
    .ROWS  (MAX_TILES_DOWN),
    .WIDTH (MAX_TILES_ACROSS)
  ) u_main_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_all (main_clr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (main_rd),
    .wr_en   (main_wr_en),
    .wr_addr (wr_addr),
    .wr_data (main_wr_data)
  );

  dtt_row_mem #(
    .ROWS  (MAX_TILES_DOWN),
    .WIDTH (MAX_TILES_ACROSS)
  ) u_nav_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_all (nav_clr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (nav_rd),
    .wr_en   (nav_wr_en),
    .wr_addr (wr_addr),
    .wr_data (nav_wr_data)
  );

  dtt_ctrl #(
    .TILE_SIZE        (TILE_SIZE),
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_tile_x           (in_tile_x),
    .in_tile_y           (in_tile_y),
    .in_x_last           (in_x_last),
    .in_all_tiles        (in_all_tiles),
    .in_end_of_pass      (in_end_of_pass),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_tile_x          (out_tile_x),
    .out_tile_y          (out_tile_y),
    .out_pixel_x         (out_pixel_x),
    .out_pixel_y         (out_pixel_y),
    .out_rect_width      (out_rect_width),
    .out_rect_height     (out_rect_height),
    .out_dirty_check     (out_dirty_check),
    .out_navigator_check (out_navigator_check),
    .out_last            (out_last),
    .gx_idx              (gx_idx),
    .gy_idx              (gy_idx),
    .gx                  (gx),
    .gy                  (gy),
    .x_limit             (x_limit),
    .rd_en               (rd_en),
    .rd_addr             (rd_addr),
    .main_rd             (main_rd),
    .nav_rd              (nav_rd),
    .wr_addr             (wr_addr),
    .main_wr_en          (main_wr_en),
    .main_wr_data        (main_wr_data),
    .nav_wr_en           (nav_wr_en),
    .nav_wr_data         (nav_wr_data),
    .main_clr            (main_clr),
    .nav_clr             (nav_clr)
  );

endmodule
